// ===== hw/rtl/jac_pkg.sv =====
// Shared types and constants for the joystick axis conditioner.
// Used by jac_ctrl, jac_dp and the top level; depends on nothing else.
`default_nettype none

package jac_pkg;

    // Sample kinds on the input channel
    localparam logic [1:0] OP_AXIS      = 2'd0;
    localparam logic [1:0] OP_BUTTON    = 2'd1;
    localparam logic [1:0] OP_HAT       = 2'd2;
    localparam logic [1:0] OP_BEGIN_CAL = 2'd3;

    // Event kinds on the output channel
    localparam logic [1:0] EV_AXIS    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;
    localparam logic [1:0] EV_HAT     = 2'd3;

    // Configuration register indexes
    localparam int          CFG_IW               = 3;
    localparam int          CFG_DW               = 8;
    localparam logic [2:0]  CFG_CALIBRATING      = 3'd0;
    localparam logic [2:0]  CFG_THROTTLE_AXIS    = 3'd1;
    localparam logic [2:0]  CFG_THROTTLE_LIMITED = 3'd2;
    localparam logic [2:0]  CFG_INVERT_MASK      = 3'd3;

    // Q1.14 limits and range presets
    localparam logic signed [15:0] AXIS_MAX   = 16'sd16384;
    localparam logic signed [15:0] AXIS_MIN   = -16'sd16384;
    localparam logic signed [15:0] CAL_LOW    = -16'sd10;
    localparam logic signed [15:0] CAL_HIGH   = 16'sd10;
    localparam logic signed [15:0] RESET_LOW  = 16'sh8000;
    localparam logic signed [15:0] RESET_HIGH = 16'sh7FFF;

    // Serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = 16;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic capture;    // latch the accepted input word
        logic prep;       // widen range, form numerator and range
        logic setup;      // scale numerator, form divisor
        logic abs_start;  // take magnitude, load divider
        logic div_step;   // one restoring divide step
        logic post;       // sign, offset and clamp the quotient
        logic emit;       // update state and load the output word
    } t_cmd;

    typedef struct packed {
        logic axis_ok;    // held word is an axis sample of a present axis
        logic div_last;   // divider is on its final step
        logic out_busy;   // output word still waits to be taken
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/jac_ctrl.sv =====
// Sequencer for the joystick axis conditioner: accepts a word, steps the
// datapath through its phases and waits for the output register. Uses jac_pkg.
`default_nettype none

module jac_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  jac_pkg::t_status i_status,
    output jac_pkg::t_cmd    o_cmd
);
    import jac_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SETUP,
        S_ABS,
        S_DIV,
        S_POST,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_ready;

    // Refuse words while reset is held
    assign o_in_ready = r_ready && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_PREP;
                        r_ready <= 1'b0;
                    end
                end
                S_PREP: begin
                    // Only axis samples need the divider
                    r_state <= i_status.axis_ok ? S_SETUP : S_EMIT;
                end
                S_SETUP: r_state <= S_ABS;
                S_ABS:   r_state <= S_DIV;
                S_DIV: begin
                    if (i_status.div_last) begin
                        r_state <= S_POST;
                    end
                end
                S_POST:  r_state <= S_EMIT;
                S_EMIT: begin
                    // Hold until the output register is free
                    if (!i_status.out_busy) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.prep      = (r_state == S_PREP) && i_status.axis_ok;
        o_cmd.setup     = (r_state == S_SETUP);
        o_cmd.abs_start = (r_state == S_ABS);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.post      = (r_state == S_POST);
        o_cmd.emit      = (r_state == S_EMIT) && !i_status.out_busy;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/jac_dp.sv =====
// Datapath for the joystick axis conditioner: configuration, axis ranges,
// serial divider, button and hat state and the output register. Uses jac_pkg.
`default_nettype none

module jac_dp #(
    parameter int NUM_AXES    = 8,
    parameter int NUM_BUTTONS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  jac_pkg::t_cmd                i_cmd,
    output jac_pkg::t_status             o_status,
    input  wire                          i_cfg_we,
    input  wire [jac_pkg::CFG_IW-1:0]    i_cfg_index,
    input  wire [jac_pkg::CFG_DW-1:0]    i_cfg_data,
    input  wire [1:0]                    i_op,
    input  wire [3:0]                    i_index,
    input  wire signed [15:0]            i_raw_value,
    input  wire                          i_pressed,
    input  wire [3:0]                    i_hat_bits,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [1:0]                   o_event_kind,
    output logic [3:0]                   o_index_res,
    output logic signed [15:0]           o_axis_value,
    output logic signed [1:0]            o_hat_x,
    output logic signed [1:0]            o_hat_y,
    output logic [15:0]                  o_button_mask
);
    import jac_pkg::*;

    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // Configuration
    logic              r_calibrating;
    logic signed [3:0] r_thr_axis;
    logic              r_thr_limited;
    logic [7:0]        r_invert;

    // Held input word
    logic [1:0]         r_op;
    logic [3:0]         r_idx;
    logic signed [15:0] r_raw;
    logic               r_pressed;
    logic [3:0]         r_hat;

    // Per-axis state
    logic signed [15:0] r_low        [NUM_AXES];
    logic signed [15:0] r_high       [NUM_AXES];
    logic signed [15:0] r_last_value [NUM_AXES];
    logic [NUM_AXES-1:0] r_last_valid;

    logic [NUM_BUTTONS-1:0] r_held;
    logic signed [1:0]      r_hx;
    logic signed [1:0]      r_hy;

    // Arithmetic pipeline
    logic signed [16:0] r_num;
    logic signed [16:0] r_den;
    logic               r_thr;
    logic signed [33:0] r_nval;
    logic [16:0]        r_dd;
    logic               r_den_bad;
    logic               r_neg;
    logic               r_ovf;
    logic [16:0]        r_rem;
    logic [15:0]        r_quo;
    logic [DIV_CW-1:0]  r_cnt;
    logic signed [15:0] r_v;

    logic               r_out_valid;
    logic [1:0]         r_ev_kind;
    logic [3:0]         r_ev_idx;
    logic signed [15:0] r_ev_val;
    logic signed [1:0]  r_ev_hx;
    logic signed [1:0]  r_ev_hy;
    logic [15:0]        r_ev_mask;

    logic [AW-1:0] a_sel;
    logic [BW-1:0] b_sel;
    logic          axis_ok;
    logic          btn_ok;

    assign a_sel   = r_idx[AW-1:0];
    assign b_sel   = r_idx[BW-1:0];
    assign axis_ok = (r_op == OP_AXIS) && ({1'b0, r_idx} < 5'(NUM_AXES));
    assign btn_ok  = ({1'b0, r_idx} < 5'(NUM_BUTTONS));

    assign o_status.axis_ok  = axis_ok;
    assign o_status.div_last = (r_cnt == DIV_CW'(DIV_STEPS - 1));
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    // ---------------- range update and numerator ----------------
    logic signed [15:0] cur_lo, cur_hi, new_lo, new_hi;
    logic signed [16:0] n_num, n_den;
    logic               is_inv, is_thr;

    always_comb begin
        cur_lo = r_low[a_sel];
        cur_hi = r_high[a_sel];
        new_lo = (r_calibrating && (r_raw < cur_lo)) ? r_raw : cur_lo;
        new_hi = (r_calibrating && (r_raw > cur_hi)) ? r_raw : cur_hi;
        is_inv = !r_idx[3] && r_invert[r_idx[2:0]];
        is_thr = !r_thr_axis[3] && !r_idx[3] && (r_thr_axis[2:0] == r_idx[2:0]);
        n_den  = {new_hi[15], new_hi} - {new_lo[15], new_lo};
        if (is_inv) begin
            n_num = {new_hi[15], new_hi} - {r_raw[15], r_raw};
        end else begin
            n_num = {r_raw[15], r_raw} - {new_lo[15], new_lo};
        end
    end

    // ---------------- scaling, magnitude, divide step ----------------
    logic signed [33:0] num_ext, n_nval;
    logic [33:0]        neg_nval;
    logic [32:0]        mag;
    logic [18:0]        trial;
    logic               take;

    always_comb begin
        num_ext  = 34'(r_num);
        // Throttle scales by half of a full-range axis
        n_nval   = (r_thr ? (num_ext <<< 15) : (num_ext <<< 16)) + 34'(r_den);
        neg_nval = -r_nval;
        mag      = r_nval[33] ? neg_nval[32:0] : r_nval[32:0];
        trial    = {1'b0, r_rem, r_quo[15]} - {2'b00, r_dd};
        take     = !trial[18];
    end

    // ---------------- sign, offset, clamp ----------------
    logic [15:0]        qa;
    logic signed [17:0] qpos, qneg, q, v18;
    logic signed [15:0] n_v;

    always_comb begin
        qa   = r_ovf ? 16'hFFFF : r_quo;
        qpos = {2'b00, qa};
        // Floor of a negative quotient rounds away from zero on a remainder
        qneg = -(qpos + 18'(|r_rem));
        q    = r_neg ? qneg : qpos;
        v18  = r_thr ? q : (q - 18'sd16384);
        if (r_thr && r_thr_limited && v18 < 0) begin
            v18 = '0;
        end
        if (v18 > 18'(AXIS_MAX)) begin
            n_v = AXIS_MAX;
        end else if (v18 < 18'(AXIS_MIN)) begin
            n_v = AXIS_MIN;
        end else begin
            n_v = v18[15:0];
        end
        if (r_den_bad) begin
            n_v = r_thr ? 16'sd0 : AXIS_MIN;
        end
    end

    // ---------------- event decision ----------------
    logic                   has_res;
    logic [1:0]             n_kind;
    logic [3:0]             n_idx;
    logic signed [15:0]     n_val;
    logic signed [1:0]      n_hx, n_hy;
    logic [NUM_BUTTONS-1:0] n_held;
    logic                   cur_btn;

    always_comb begin
        has_res = 1'b0;
        n_kind  = EV_AXIS;
        n_idx   = r_idx;
        n_val   = '0;
        n_held  = r_held;
        cur_btn = r_held[b_sel];
        n_hx    = r_hat[1] ? 2'sb01 : (r_hat[3] ? 2'sb11 : 2'sb00);
        n_hy    = r_hat[2] ? 2'sb11 : (r_hat[0] ? 2'sb01 : 2'sb00);
        case (r_op)
            OP_AXIS: begin
                if (axis_ok && !(r_last_valid[a_sel] && r_last_value[a_sel] == r_v)) begin
                    has_res = 1'b1;
                    n_val   = r_v;
                end
            end
            OP_BUTTON: begin
                if (btn_ok && (r_pressed != cur_btn)) begin
                    has_res       = 1'b1;
                    n_kind        = r_pressed ? EV_PRESS : EV_RELEASE;
                    n_held[b_sel] = r_pressed;
                end
            end
            OP_HAT: begin
                if (n_hx != r_hx || n_hy != r_hy) begin
                    has_res = 1'b1;
                    n_kind  = EV_HAT;
                    n_idx   = '0;
                end
            end
            default: ;
        endcase
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calibrating <= 1'b0;
            r_thr_axis    <= -4'sd1;
            r_thr_limited <= 1'b0;
            r_invert      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CALIBRATING:      r_calibrating <= i_cfg_data[0];
                    CFG_THROTTLE_AXIS:    r_thr_axis    <= i_cfg_data[3:0];
                    CFG_THROTTLE_LIMITED: r_thr_limited <= i_cfg_data[0];
                    CFG_INVERT_MASK:      r_invert      <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.emit && r_op == OP_BEGIN_CAL) begin
                r_calibrating <= 1'b1;
            end
        end
    end

    // ---------------- persistent state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_low[i]        <= RESET_LOW;
                r_high[i]       <= RESET_HIGH;
                r_last_value[i] <= '0;
            end
            r_last_valid <= '0;
            r_held       <= '0;
            r_hx         <= '0;
            r_hy         <= '0;
        end else begin
            if (i_cmd.prep) begin
                r_low[a_sel]  <= new_lo;
                r_high[a_sel] <= new_hi;
            end
            if (i_cmd.emit) begin
                if (r_op == OP_BEGIN_CAL) begin
                    for (int i = 0; i < NUM_AXES; i++) begin
                        r_low[i]  <= CAL_LOW;
                        r_high[i] <= CAL_HIGH;
                    end
                end
                if (has_res && r_op == OP_AXIS) begin
                    r_last_valid[a_sel] <= 1'b1;
                    r_last_value[a_sel] <= r_v;
                end
                r_held <= n_held;
                if (r_op == OP_HAT) begin
                    r_hx <= n_hx;
                    r_hy <= n_hy;
                end
            end
        end
    end

    // ---------------- input word and arithmetic pipeline ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_op;
            r_idx     <= i_index;
            r_raw     <= i_raw_value;
            r_pressed <= i_pressed;
            r_hat     <= i_hat_bits;
        end
        if (i_cmd.prep) begin
            r_num <= n_num;
            r_den <= n_den;
            r_thr <= is_thr;
        end
        if (i_cmd.setup) begin
            r_nval    <= n_nval;
            r_dd      <= {r_den[15:0], 1'b0};
            r_den_bad <= r_den[16] || (r_den == '0);
        end
        if (i_cmd.abs_start) begin
            r_neg <= r_nval[33];
            r_rem <= mag[32:16];
            r_quo <= mag[15:0];
            // Quotient beyond 16 bits saturates anyway
            r_ovf <= (mag[32:16] >= r_dd);
        end
        if (i_cmd.div_step) begin
            r_rem <= take ? trial[16:0] : {r_rem[15:0], r_quo[15]};
            r_quo <= {r_quo[14:0], take};
        end
        if (i_cmd.post) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.abs_start) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit && has_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && has_res) begin
            r_ev_kind <= n_kind;
            r_ev_idx  <= n_idx;
            r_ev_val  <= n_val;
            r_ev_hx   <= (r_op == OP_HAT) ? n_hx : 2'sb00;
            r_ev_hy   <= (r_op == OP_HAT) ? n_hy : 2'sb00;
            r_ev_mask <= 16'(n_held);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_ev_kind;
    assign o_index_res   = r_ev_idx;
    assign o_axis_value  = r_ev_val;
    assign o_hat_x       = r_ev_hx;
    assign o_hat_y       = r_ev_hy;
    assign o_button_mask = r_ev_mask;

endmodule

`default_nettype wire

// ===== hw/rtl/joystick_axis_conditioner.sv =====
// Top level of the joystick axis conditioner: joins the sequencer and the
// datapath. Uses jac_pkg, jac_ctrl and jac_dp.
`default_nettype none

// Conditions one joystick sample per input word. The word is latched at the
// edge that accepts it; an axis sample then steps through widening the
// calibration range, scaling, taking the magnitude, the one-bit-per-cycle
// restoring divider, sign/clamp and emit. Button, hat and begin-calibration
// words, and absent-axis samples, go from prep straight to emit. One word is in
// work at a time; o_in_ready rises again once the result is loaded into the
// output register, so the next word may be accepted while that result still
// waits for i_out_ready. The emit step holds while the output register still
// carries a word not yet taken, so a stalled receiver stalls the input.
// o_in_ready is low while reset is held. A word that produces no event
// (unchanged axis value, repeated button level, same hat direction, absent axis
// or button, begin calibration) gives no output word.
// Configuration registers: 0 calibrating, 1 throttle axis (signed, -1 none),
// 2 throttle limited, 3 invert mask; write them only while the block is idle.
module joystick_axis_conditioner #(
    parameter int NUM_AXES    = 8,
    parameter int NUM_BUTTONS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [jac_pkg::CFG_IW-1:0]    i_cfg_index,
    input  wire [jac_pkg::CFG_DW-1:0]    i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire [1:0]                    i_op,
    input  wire [3:0]                    i_index,
    input  wire signed [15:0]            i_raw_value,
    input  wire                          i_pressed,
    input  wire [3:0]                    i_hat_bits,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [1:0]                   o_event_kind,
    output logic [3:0]                   o_index_res,
    output logic signed [15:0]           o_axis_value,
    output logic signed [1:0]            o_hat_x,
    output logic signed [1:0]            o_hat_y,
    output logic [15:0]                  o_button_mask
);
    import jac_pkg::*;

    t_cmd    cmd;
    t_status status;

    jac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    jac_dp #(
        .NUM_AXES    (NUM_AXES),
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_index       (i_index),
        .i_raw_value   (i_raw_value),
        .i_pressed     (i_pressed),
        .i_hat_bits    (i_hat_bits),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_kind  (o_event_kind),
        .o_index_res   (o_index_res),
        .o_axis_value  (o_axis_value),
        .o_hat_x       (o_hat_x),
        .o_hat_y       (o_hat_y),
        .o_button_mask (o_button_mask)
    );

endmodule

`default_nettype wire

// ===== tb/sv/joystick_axis_conditioner_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for joystick_axis_conditioner: directed table, then random sample words
// under mixed sender/receiver idling, checked against a bit-exact predictor. Uses jac_pkg.

module joystick_axis_conditioner_tb;
    import jac_pkg::*;

    localparam int NUM_AXES      = 8;
    localparam int NUM_BUTTONS   = 16;
    localparam int Q_UNIT        = 16384;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_WORDS   = 195;
    localparam int HOLD_CYCLES   = 300;

    typedef enum logic [1:0] {
        ROW_PREDICT,  // expected event comes from the predictor
        ROW_NONE,     // no event may come
        ROW_EVENT,    // expected event typed into the row
        ROW_CFG       // register write: index in smp.index, data in smp.raw[7:0]
    } t_row_kind;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  index;
        logic [15:0] raw;
        logic        pressed;
        logic [3:0]  hat;
    } t_joy_sample;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  index;
        logic [15:0] value;
        logic [1:0]  hat_x;
        logic [1:0]  hat_y;
        logic [15:0] mask;
    } t_joy_event;

    typedef struct packed {
        t_row_kind   tag;
        t_joy_sample smp;
        t_joy_event  ev;
    } t_dir_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CFG_IW-1:0]   i_cfg_index = '0;
    logic [CFG_DW-1:0]   i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic [1:0]          i_op        = '0;
    logic [3:0]          i_index     = '0;
    logic signed [15:0]  i_raw_value = '0;
    logic                i_pressed   = 1'b0;
    logic [3:0]          i_hat_bits  = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [1:0]          o_event_kind;
    logic [3:0]          o_index_res;
    logic signed [15:0]  o_axis_value;
    logic signed [1:0]   o_hat_x;
    logic signed [1:0]   o_hat_y;
    logic [15:0]         o_button_mask;

    joystick_axis_conditioner dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_index      (i_index),
        .i_raw_value  (i_raw_value),
        .i_pressed    (i_pressed),
        .i_hat_bits   (i_hat_bits),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_kind (o_event_kind),
        .o_index_res  (o_index_res),
        .o_axis_value (o_axis_value),
        .o_hat_x      (o_hat_x),
        .o_hat_y      (o_hat_y),
        .o_button_mask(o_button_mask)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Predictor copy of registers and state
    logic        cal_q;
    logic [3:0]  thr_q;
    logic        lim_q;
    logic [7:0]  inv_q;
    int          rng_lo [NUM_AXES];
    int          rng_hi [NUM_AXES];
    int          prev_val [NUM_AXES];
    bit          prev_seen [NUM_AXES];
    logic [15:0] held_mask;
    int          hat_dx;
    int          hat_dy;

    t_joy_event  events_due [$];
    t_joy_event  due_head;
    t_dir_row    dir_tab [$];

    int mismatches    = 0;
    int words_sent    = 0;
    int events_seen   = 0;
    int cfg_writes    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int holds_asked   = 0;
    int holds_taken   = 0;
    int hold_left     = 0;

    function automatic longint floor_quot(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // Advance the predictor by one sample; return 1 when it yields an event
    function automatic bit condition_sample(input t_joy_sample s, output t_joy_event ev);
        int          a;
        int          r;
        int          ta;
        int          nx;
        int          ny;
        int          i;
        longint      num;
        longint      den;
        longint      v;
        bit          thr;
        logic [15:0] bitm;
        ev = '0;
        a  = int'(s.index);
        r  = int'($signed(s.raw));
        case (s.op)
            OP_AXIS: begin
                if (a >= NUM_AXES)
                    return 1'b0;
                if (cal_q) begin
                    if (r < rng_lo[a]) rng_lo[a] = r;
                    if (r > rng_hi[a]) rng_hi[a] = r;
                end
                den = longint'(rng_hi[a] - rng_lo[a]);
                num = longint'(inv_q[a] ? rng_hi[a] - r : r - rng_lo[a]);
                ta  = int'($signed(thr_q));
                thr = (ta >= 0) && (ta == a);
                if (den <= 0) begin
                    v = thr ? 0 : -Q_UNIT;
                end else if (thr) begin
                    v = floor_quot(num * (2 * Q_UNIT) + den, 2 * den);
                    if (lim_q && v < 0) v = 0;
                end else begin
                    v = floor_quot(num * (4 * Q_UNIT) + den, 2 * den) - Q_UNIT;
                end
                if (v > Q_UNIT) v = Q_UNIT;
                if (v < -Q_UNIT) v = -Q_UNIT;
                // report only a changed value, or the first one
                if (prev_seen[a] && prev_val[a] == v)
                    return 1'b0;
                prev_seen[a] = 1'b1;
                prev_val[a]  = int'(v);
                ev.kind  = EV_AXIS;
                ev.index = s.index;
                ev.value = v[15:0];
                ev.mask  = held_mask;
                return 1'b1;
            end
            OP_BUTTON: begin
                if (a >= NUM_BUTTONS)
                    return 1'b0;
                bitm = 16'h0001 << a;
                if (s.pressed && (held_mask & bitm) == 0) begin
                    held_mask = held_mask | bitm;
                    ev.kind   = EV_PRESS;
                end else if (!s.pressed && (held_mask & bitm) != 0) begin
                    held_mask = held_mask & ~bitm;
                    ev.kind   = EV_RELEASE;
                end else begin
                    return 1'b0;
                end
                ev.index = s.index;
                ev.mask  = held_mask;
                return 1'b1;
            end
            OP_HAT: begin
                ny = 0;
                nx = 0;
                if (s.hat[0]) ny = 1;
                if (s.hat[2]) ny = -1;  // down over up
                if (s.hat[3]) nx = -1;
                if (s.hat[1]) nx = 1;   // right over left
                if (nx == hat_dx && ny == hat_dy)
                    return 1'b0;
                hat_dx   = nx;
                hat_dy   = ny;
                ev.kind  = EV_HAT;
                ev.hat_x = nx[1:0];
                ev.hat_y = ny[1:0];
                ev.mask  = held_mask;
                return 1'b1;
            end
            default: begin
                cal_q = 1'b1;
                for (i = 0; i < NUM_AXES; i++) begin
                    rng_lo[i] = int'(CAL_LOW);
                    rng_hi[i] = int'(CAL_HIGH);
                end
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic t_dir_row tab_row(input t_row_kind tag, input int op, input int idx,
                                         input int raw, input int pr, input int hat,
                                         input int ek, input int ei, input int ev,
                                         input int hx, input int hy, input int em);
        t_dir_row r;
        r.tag         = tag;
        r.smp.op      = op[1:0];
        r.smp.index   = idx[3:0];
        r.smp.raw     = raw[15:0];
        r.smp.pressed = pr[0];
        r.smp.hat     = hat[3:0];
        r.ev.kind     = ek[1:0];
        r.ev.index    = ei[3:0];
        r.ev.value    = ev[15:0];
        r.ev.hat_x    = hx[1:0];
        r.ev.hat_y    = hy[1:0];
        r.ev.mask     = em[15:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Offer one word; return at the edge where it is taken
    task automatic offer_word(input t_joy_sample s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= s.op;
        i_index     <= s.index;
        i_raw_value <= s.raw;
        i_pressed   <= s.pressed;
        i_hat_bits  <= s.hat;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        words_sent++;
    endtask

    // Drop valid, wait for every pending event, then let a no-event word finish
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (events_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CALIBRATING:      cal_q = data[0];
            CFG_THROTTLE_AXIS:    thr_q = data[3:0];
            CFG_THROTTLE_LIMITED: lim_q = data[0];
            CFG_INVERT_MASK:      inv_q = data;
            default: ;
        endcase
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic run_row(input t_dir_row row);
        t_joy_event ev;
        bit         fired;
        if (row.tag == ROW_CFG) begin
            settle_block();
            cfg_write(row.smp.index[CFG_IW-1:0], row.smp.raw[CFG_DW-1:0]);
        end else begin
            offer_word(row.smp);
            fired = condition_sample(row.smp, ev);
            if (row.tag == ROW_EVENT)
                events_due.push_back(row.ev);
            else if (row.tag == ROW_PREDICT && fired)
                events_due.push_back(ev);
        end
    endtask

    task automatic run_phase(input logic [7:0] cal, input logic [7:0] thr, input logic [7:0] lim,
                             input logic [7:0] inv, input int send_pct, input int stall,
                             input bit pressure);
        t_joy_sample s;
        t_dir_row    row;
        int          counted;
        int          pick;
        int          tmp;
        settle_block();
        send_idle_pct = send_pct;
        stall_pct     = stall;
        cfg_write(CFG_CALIBRATING, cal);
        cfg_write(CFG_THROTTLE_AXIS, thr);
        cfg_write(CFG_THROTTLE_LIMITED, lim);
        cfg_write(CFG_INVERT_MASK, inv);
        if (pressure)
            holds_asked++;
        counted = 0;
        while (counted < PHASE_WORDS) begin
            // randomize every field, then shape the ones the op uses
            s.op      = 2'($urandom_range(3));
            s.index   = 4'($urandom_range(15));
            s.raw     = 16'($urandom_range(65535));
            s.pressed = 1'($urandom_range(1));
            s.hat     = 4'($urandom_range(15));
            pick      = $urandom_range(99);
            if (pick < 52) begin
                s.op = OP_AXIS;
                if ($urandom_range(9) != 0)
                    s.index = 4'($urandom_range(NUM_AXES - 1));
                pick = $urandom_range(9);
                if (pick < 2) begin
                    s.raw = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                end else if (pick < 6) begin
                    tmp   = $urandom_range(40);
                    tmp   = tmp - 20;
                    s.raw = tmp[15:0];
                end
            end else if (pick < 76) begin
                s.op = OP_BUTTON;
            end else if (pick < 97) begin
                s.op = OP_HAT;
            end else begin
                s.op = OP_BEGIN_CAL;
            end
            row.tag = ROW_PREDICT;
            row.smp = s;
            row.ev  = '0;
            if (!(s.op == OP_AXIS && s.index >= NUM_AXES))
                counted++;
            run_row(row);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (holds_taken != holds_asked) begin
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            holds_taken <= holds_taken + 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each taken event word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            events_seen++;
            if (events_due.size() == 0) begin
                flag_mismatch($sformatf("event kind %0d index %0d with nothing pending",
                                        o_event_kind, o_index_res));
            end else begin
                due_head = events_due.pop_front();
                if (o_event_kind !== due_head.kind)
                    flag_mismatch($sformatf("event_kind got %0d want %0d",
                                            o_event_kind, due_head.kind));
                if (o_index_res !== due_head.index)
                    flag_mismatch($sformatf("index_res got %0d want %0d",
                                            o_index_res, due_head.index));
                if (o_axis_value !== due_head.value)
                    flag_mismatch($sformatf("axis_value got %0d want %0d",
                                            o_axis_value, $signed(due_head.value)));
                if (o_hat_x !== due_head.hat_x)
                    flag_mismatch($sformatf("hat_x got %0d want %0d",
                                            o_hat_x, $signed(due_head.hat_x)));
                if (o_hat_y !== due_head.hat_y)
                    flag_mismatch($sformatf("hat_y got %0d want %0d",
                                            o_hat_y, $signed(due_head.hat_y)));
                if (o_button_mask !== due_head.mask)
                    flag_mismatch($sformatf("button_mask got %h want %h",
                                            o_button_mask, due_head.mask));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d events still pending",
                 cycle_count, events_due.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int k;
        cal_q     = 1'b0;
        thr_q     = 4'hF;
        lim_q     = 1'b0;
        inv_q     = 8'h00;
        held_mask = 16'h0000;
        hat_dx    = 0;
        hat_dy    = 0;
        for (k = 0; k < NUM_AXES; k++) begin
            rng_lo[k]    = int'(RESET_LOW);
            rng_hi[k]    = int'(RESET_HIGH);
            prev_val[k]  = 0;
            prev_seen[k] = 1'b0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // op, index, raw, pressed, hat | kind, index, value, hat_x, hat_y, mask
        dir_tab.push_back(tab_row(ROW_EVENT, OP_AXIS, 0, -32768, 1, 15,
                                  EV_AXIS, 0, -16384, 0, 0, 16'h0000));
        dir_tab.push_back(tab_row(ROW_NONE, OP_AXIS, 0, -32768, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_EVENT, OP_AXIS, 0, 32767, 0, 0,
                                  EV_AXIS, 0, 16384, 0, 0, 16'h0000));
        dir_tab.push_back(tab_row(ROW_NONE, OP_AXIS, 15, 100, 1, 6, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_EVENT, OP_BUTTON, 0, 0, 1, 0,
                                  EV_PRESS, 0, 0, 0, 0, 16'h0001));
        dir_tab.push_back(tab_row(ROW_NONE, OP_BUTTON, 0, 1234, 1, 9, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_EVENT, OP_BUTTON, 15, -1, 1, 0,
                                  EV_PRESS, 15, 0, 0, 0, 16'h8001));
        dir_tab.push_back(tab_row(ROW_EVENT, OP_BUTTON, 0, 0, 0, 0,
                                  EV_RELEASE, 0, 0, 0, 0, 16'h8000));
        dir_tab.push_back(tab_row(ROW_EVENT, OP_BUTTON, 15, 0, 0, 15,
                                  EV_RELEASE, 15, 0, 0, 0, 16'h0000));
        dir_tab.push_back(tab_row(ROW_NONE, OP_BUTTON, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_NONE, OP_HAT, 7, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_EVENT, OP_HAT, 0, 0, 0, 1,
                                  EV_HAT, 0, 0, 0, 1, 16'h0000));
        dir_tab.push_back(tab_row(ROW_EVENT, OP_HAT, 0, 0, 0, 5,
                                  EV_HAT, 0, 0, 0, -1, 16'h0000));
        dir_tab.push_back(tab_row(ROW_EVENT, OP_HAT, 0, 0, 0, 10,
                                  EV_HAT, 0, 0, 1, 0, 16'h0000));
        dir_tab.push_back(tab_row(ROW_EVENT, OP_HAT, 0, 0, 0, 15,
                                  EV_HAT, 0, 0, 1, -1, 16'h0000));
        dir_tab.push_back(tab_row(ROW_EVENT, OP_HAT, 0, 0, 0, 8,
                                  EV_HAT, 0, 0, -1, 0, 16'h0000));
        dir_tab.push_back(tab_row(ROW_NONE, OP_BEGIN_CAL, 9, 77, 1, 3, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_PREDICT, OP_AXIS, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_PREDICT, OP_AXIS, 2, 32767, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_EVENT, OP_AXIS, 3, -32768, 0, 0,
                                  EV_AXIS, 3, -16384, 0, 0, 16'h0000));
        dir_tab.push_back(tab_row(ROW_PREDICT, OP_AXIS, 4, 5, 0, 0, 0, 0, 0, 0, 0, 0));
        // inverted throttle on axis 2, clamped below; index past the list is ignored
        dir_tab.push_back(tab_row(ROW_CFG, 0, CFG_THROTTLE_AXIS, 8'h02, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_CFG, 0, CFG_THROTTLE_LIMITED, 8'h01, 0, 0,
                                  0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_CFG, 0, CFG_INVERT_MASK, 8'h04, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_CFG, 0, 6, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_PREDICT, OP_AXIS, 2, 32767, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_PREDICT, OP_AXIS, 2, -32768, 0, 0, 0, 0, 0, 0, 0, 0));
        // throttle index below -1 selects no axis
        dir_tab.push_back(tab_row(ROW_CFG, 0, CFG_CALIBRATING, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_CFG, 0, CFG_THROTTLE_AXIS, 8'h08, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_PREDICT, OP_AXIS, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // limited throttle driven below its range
        dir_tab.push_back(tab_row(ROW_CFG, 0, CFG_THROTTLE_AXIS, 8'h04, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(tab_row(ROW_PREDICT, OP_AXIS, 4, -32768, 0, 0, 0, 0, 0, 0, 0, 0));

        for (k = 0; k < dir_tab.size(); k++)
            run_row(dir_tab[k]);

        run_phase(8'h00, 8'h0F, 8'h00, 8'h00, 0, 0, 1'b0);
        run_phase(8'h01, 8'h07, 8'h01, 8'hFF, 50, 0, 1'b0);
        run_phase(8'hFE, 8'h00, 8'h00, 8'hA5, 0, 50, 1'b1);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 34, 34, 1'b0);
        settle_block();

        if (events_due.size() != 0)
            flag_mismatch($sformatf("%0d expected events never arrived", events_due.size()));
        $display("covered %0d sample words and %0d register writes; %0d event words checked",
                 words_sent, cfg_writes, events_seen);
        $display("idle mixes: none, sender 50%%, receiver 50%% with long hold-off, both 34%%");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
